@@ rtl/core/daily_alarm_schedule_table_core_defines.svh @@
// assertion macros for the daily alarm schedule table core
`ifndef DAILY_ALARM_SCHEDULE_TABLE_CORE_DEFINES_SVH
`define DAILY_ALARM_SCHEDULE_TABLE_CORE_DEFINES_SVH

// implication checked in the same cycle
`define DAST_ASSERT_NOW(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// implication checked in the next cycle
`define DAST_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/dast_pkg.sv @@
// types, codes and microcode program of the daily alarm schedule table
`timescale 1ns / 1ps
`default_nettype none

package dast_pkg;

    localparam int unsigned MINUTES_PER_DAY  = 24 * 60;
    localparam int unsigned MINUTES_PER_HOUR = 60;

    // command codes
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_ADD  = 2'd1;
    localparam logic [1:0] CMD_DEL  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // microcode step addresses
    localparam int unsigned STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;
    localparam step_t STEP_IDLE  = 3'd0;
    localparam step_t STEP_SCAN  = 3'd1;
    localparam step_t STEP_SHIFT = 3'd2;
    localparam step_t STEP_DRAIN = 3'd3;
    localparam step_t STEP_FIN   = 3'd4;
    localparam int unsigned PROG_LEN = 5;

    typedef enum logic [1:0] {
        SEQ_FETCH,
        SEQ_LOOP,
        SEQ_NEXT,
        SEQ_EMIT
    } seq_t;

    typedef struct packed {
        seq_t  seq;
        logic  rd;
        logic  rd_shift;
        logic  emit;
        step_t target;
    } ctrl_word_t;

    localparam ctrl_word_t PROGRAM [PROG_LEN] = '{
        '{seq: SEQ_FETCH, rd: 1'b0, rd_shift: 1'b0, emit: 1'b0, target: STEP_IDLE},
        '{seq: SEQ_LOOP,  rd: 1'b1, rd_shift: 1'b0, emit: 1'b0, target: STEP_DRAIN},
        '{seq: SEQ_LOOP,  rd: 1'b1, rd_shift: 1'b1, emit: 1'b0, target: STEP_DRAIN},
        '{seq: SEQ_NEXT,  rd: 1'b0, rd_shift: 1'b0, emit: 1'b0, target: STEP_FIN},
        '{seq: SEQ_EMIT,  rd: 1'b0, rd_shift: 1'b0, emit: 1'b1, target: STEP_IDLE}
    };

    typedef struct packed {
        logic [5:0] minute;
        logic [4:0] hour;
    } entry_t;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] entry_count;
        logic [5:0] next_minute;
        logic [4:0] next_hour;
        logic       next_valid;
        logic       fire;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/core/daily_alarm_schedule_table_core.sv @@
// daily alarm schedule table core: microcoded scan over a table of alarm times
//
// input stream: s_axis_tuser carries the command (tick, add, delete), s_axis_tdata
// carries hour, minute and entry index. one result transaction leaves on the
// m_axis group per accepted input transaction, in order.
// tick and add walk the stored entries once through the single table read port,
// one entry per cycle (an empty table still passes through the scan step), then
// pass a drain step and a finish step that writes the result, after which the
// next command is taken.
// delete moves each later entry down one place per cycle, then drains and finishes;
// delete on an empty table and the unused code go straight to the finish step.
// one command is worked at a time; s_axis_tready is high only between commands.
// the result sits in an output register; the next command is accepted while it
// waits, and a stalled receiver only holds the finish step of that next command.
// reset empties the table (count zero), forgets the last firing time and drops
// any pending result; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

`include "daily_alarm_schedule_table_core_defines.svh"

module daily_alarm_schedule_table_core #(
    parameter int unsigned MAX_ENTRIES = 20
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // hour[4:0], minute[10:5], entry_index[15:11]
    input  wire logic [1:0]  s_axis_tuser,   // command[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata    // fire, next_valid, next_hour, next_minute,
                                             // entry_count, status, zero pad
);
    import dast_pkg::*;

    localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned XW = (CW > 5) ? CW : 5;
    localparam int unsigned TW = 11;
    localparam int unsigned DW = 13;

    // microcode sequencer
    step_t      step_reg, step_next;
    ctrl_word_t cw;
    logic       accept, stall, more;
    step_t      dispatch;

    // datapath registers
    logic [1:0]        cmd_reg, cmd_next;
    logic [4:0]        hour_reg, hour_next;
    logic [5:0]        minute_reg, minute_next;
    logic [TW-1:0]     now_reg, now_next;
    logic [CW-1:0]     ptr_reg, ptr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     eidx_reg, eidx_next;
    logic              hit_reg, hit_next;
    logic signed [DW-1:0] best_d_reg, best_d_next;
    entry_t            best_reg, best_next;
    logic [4:0]        lf_hour_reg, lf_hour_next;
    logic [5:0]        lf_minute_reg, lf_minute_next;
    logic              lf_valid_reg, lf_valid_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;

    // table storage
    entry_t        mem [MAX_ENTRIES];
    entry_t        rd_data_reg;
    logic [CW-1:0] rd_addr;
    logic          rd_en;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;

    // scan evaluation
    logic [TW-1:0]        ent_t;
    logic signed [DW-1:0] ent_dist;
    logic                 ent_hit;
    logic [XW-1:0]        idx_x, last_x;
    logic                 fire;

    assign cw            = PROGRAM[step_reg];
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (step_reg == STEP_IDLE);
    assign stall         = cw.emit && out_valid_reg && !m_axis_tready;
    assign rd_addr       = ptr_reg + CW'(cw.rd_shift);
    assign rd_en         = cw.rd && (rd_addr < count_reg);
    assign more          = ({1'b0, rd_addr} + (CW+1)'(1)) < {1'b0, count_reg};
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_reg};

    assign ent_t   = TW'(rd_data_reg.hour) * TW'(MINUTES_PER_HOUR) + TW'(rd_data_reg.minute);
    assign ent_hit = (rd_data_reg.hour == hour_reg) && (rd_data_reg.minute == minute_reg);
    assign idx_x   = XW'(s_axis_tdata[15:11]);
    assign last_x  = XW'(count_reg - CW'(1));
    assign fire    = hit_reg && !(lf_valid_reg && lf_hour_reg == hour_reg
                                  && lf_minute_reg == minute_reg);

    always_comb
    begin
        ent_dist = $signed(DW'(ent_t)) - $signed(DW'(now_reg));
        if (ent_dist <= 0)
        begin
            ent_dist = ent_dist + DW'(MINUTES_PER_DAY);
        end
    end

    always_comb
    begin
        case (s_axis_tuser)
            CMD_TICK, CMD_ADD: dispatch = STEP_SCAN;
            CMD_DEL:           dispatch = (count_reg == '0) ? STEP_FIN : STEP_SHIFT;
            default:           dispatch = STEP_FIN;
        endcase
    end

    always_comb
    begin
        case (cw.seq)
            SEQ_FETCH: step_next = accept ? dispatch : step_reg;
            SEQ_LOOP:  step_next = more ? step_reg : cw.target;
            SEQ_NEXT:  step_next = step_reg + STEP_W'(1);
            SEQ_EMIT:  step_next = stall ? step_reg : cw.target;
            default:   step_next = STEP_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_next       = cmd_reg;
        hour_next      = hour_reg;
        minute_next    = minute_reg;
        now_next       = now_reg;
        ptr_next       = ptr_reg;
        count_next     = count_reg;
        pend_next      = 1'b0;
        eidx_next      = eidx_reg;
        hit_next       = hit_reg;
        best_d_next    = best_d_reg;
        best_next      = best_reg;
        lf_hour_next   = lf_hour_reg;
        lf_minute_next = lf_minute_reg;
        lf_valid_next  = lf_valid_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_next       = out_reg;
        wr_en          = 1'b0;
        wr_addr        = eidx_reg;
        wr_data        = rd_data_reg;

        if (accept)
        begin
            cmd_next    = s_axis_tuser;
            hour_next   = s_axis_tdata[4:0];
            minute_next = s_axis_tdata[10:5];
            now_next    = TW'(s_axis_tdata[4:0]) * TW'(MINUTES_PER_HOUR)
                        + TW'(s_axis_tdata[10:5]);
            hit_next    = 1'b0;
            if (s_axis_tuser == CMD_DEL)
            begin
                ptr_next = (idx_x > last_x) ? CW'(last_x) : CW'(idx_x);
            end
            else
            begin
                ptr_next = '0;
            end
        end

        if (cw.rd)
        begin
            pend_next = rd_en;
            eidx_next = AW'(ptr_reg);
            ptr_next  = ptr_reg + CW'(1);
        end

        // results of the read issued in the previous cycle
        if (pend_reg)
        begin
            if (cmd_reg == CMD_DEL)
            begin
                wr_en = 1'b1;
            end
            else
            begin
                hit_next = hit_reg || ent_hit;
                if (eidx_reg == '0 || ent_dist < best_d_reg)
                begin
                    best_d_next = ent_dist;
                    best_next   = rd_data_reg;
                end
            end
        end

        if (cw.emit && !stall)
        begin
            out_valid_next = 1'b1;
            out_next       = '0;
            case (cmd_reg)
                CMD_TICK:
                begin
                    out_next.fire = fire;
                    if (fire)
                    begin
                        lf_hour_next   = hour_reg;
                        lf_minute_next = minute_reg;
                        lf_valid_next  = 1'b1;
                    end
                    if (count_reg != '0)
                    begin
                        out_next.next_valid  = 1'b1;
                        out_next.next_hour   = best_reg.hour;
                        out_next.next_minute = best_reg.minute;
                    end
                end
                CMD_ADD:
                begin
                    if (hit_reg)
                    begin
                        out_next.status = ST_DUP;
                    end
                    else if (count_reg >= CW'(MAX_ENTRIES))
                    begin
                        out_next.status = ST_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = AW'(count_reg);
                        wr_data    = '{hour: hour_reg, minute: minute_reg};
                        count_next = count_reg + CW'(1);
                    end
                end
                CMD_DEL:
                begin
                    if (count_reg == '0)
                    begin
                        out_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
                default:
                begin
                    out_next.status = ST_OK;
                end
            endcase
            out_next.entry_count = 5'(count_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[AW'(rd_addr)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            lf_hour_reg   <= '0;
            lf_minute_reg <= '0;
            lf_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            lf_hour_reg   <= lf_hour_next;
            lf_minute_reg <= lf_minute_next;
            lf_valid_reg  <= lf_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        hour_reg   <= hour_next;
        minute_reg <= minute_next;
        now_reg    <= now_next;
        ptr_reg    <= ptr_next;
        eidx_reg   <= eidx_next;
        hit_reg    <= hit_next;
        best_d_reg <= best_d_next;
        best_reg   <= best_next;
        out_reg    <= out_next;
    end

    // table never holds more than its depth
    `DAST_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(MAX_ENTRIES), "entry count overflow")
    // pending reads only come from stored entries
    `DAST_ASSERT_NOW(a_read_in_range, pend_reg, CW'(eidx_reg) < count_reg, "read beyond count")
    // no read in flight when a new command can be taken
    `DAST_ASSERT_NOW(a_idle_drained, s_axis_tready, !pend_reg, "read pending while idle")
    // a finished command leaves the finish step unless the output is stalled
    `DAST_ASSERT_NEXT(a_fin_leaves, cw.emit && !stall, step_reg == STEP_IDLE, "finish step stuck")

endmodule

`default_nettype wire
